### sv/text_console_writer_defines.svh
// ----------------------------------------------------------------------------
// Text console writer assertion macros
// Shared property forms that use the block clock and its asynchronous reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_WRITER_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_DEFINES_SVH

// The condition implies the check in the same cycle.
`define TCW_ASSERT_IMPL(label, cond, check) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |-> (check)) \
		else $error("text console writer: same-cycle check failed");

// The condition implies the check in the next cycle.
`define TCW_ASSERT_NEXT(label, cond, check) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (check)) \
		else $error("text console writer: next-cycle check failed");

`endif

### sv/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Geometry constants, command codes, word types and sequencer states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tcw_pkg;

	// Screen geometry.
	localparam int COLUMNS = 80;
	localparam int ROWS    = 25;
	localparam int CELLS   = COLUMNS * ROWS;
	localparam int ADDR_W  = $clog2(CELLS);
	localparam int COL_W   = 7;
	localparam int ROW_W   = 5;

	// Sweep end points.
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);

	// Cell constants.
	localparam logic [15:0] BLANK_CELL  = 16'h0020;
	localparam logic [15:0] SCROLL_CELL = 16'h0F20;
	localparam logic [7:0]  BLANK_CHAR  = 8'h20;
	localparam logic [7:0]  NEWLINE     = 8'd10;

	// Command codes.
	localparam logic [2:0] OP_WRITE = 3'd0;
	localparam logic [2:0] OP_PUT   = 3'd1;
	localparam logic [2:0] OP_SET   = 3'd2;
	localparam logic [2:0] OP_CLEAR = 3'd3;
	localparam logic [2:0] OP_READ  = 3'd4;

	// Command word.
	typedef struct packed {
		logic [2:0] op;
		logic [7:0] char_code;
		logic [7:0] col;
		logic [7:0] row;
		logic [3:0] fg_color;
		logic [3:0] bg_color;
	} cmd_word_t;

	// Response word.
	typedef struct packed {
		logic [COL_W-1:0]  cursor_col;
		logic [ROW_W-1:0]  cursor_row;
		logic [ADDR_W-1:0] cursor_index;
		logic [15:0]       cell_data;
	} rsp_word_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_EXEC,
		ST_READ,
		ST_SCROLL,
		ST_FILL,
		ST_CLEAR,
		ST_RESULT
	} state_t;

	// Builds a cell from its character and colors.
	function automatic logic [15:0] make_cell(logic [7:0] ch, logic [3:0] fg, logic [3:0] bg);
		make_cell = {bg, fg, ch};
	endfunction

endpackage

### sv/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// A command passes through EXEC and RESULT, and a read that is in range also through READ;
// its response word is registered in RESULT. A scroll adds a row copy and a bottom-row fill
// and a clear adds a sweep of every cell; the single store port pair sets these sweep lengths.
// After reset the store is swept to blanks while cmd_stall is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "text_console_writer_defines.svh"

module text_console_writer (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	output logic               cmd_stall,
	input  tcw_pkg::cmd_word_t cmd,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output tcw_pkg::rsp_word_t rsp
);
	import tcw_pkg::*;

	// Control registers.
	state_t            state_q, state_d;
	logic [ADDR_W-1:0] sweep_q;
	logic              copy_pend_q;
	logic [COL_W-1:0]  cur_col_q;
	logic [ROW_W-1:0]  cur_row_q;
	logic              rsp_valid_q;

	// Payload registers.
	cmd_word_t         item_q;
	logic [ADDR_W-1:0] copy_addr_q;
	logic [15:0]       fill_q;
	logic [15:0]       cell_q;
	logic [15:0]       rd_data_q;
	rsp_word_t         rsp_q;

	// Text store.
	logic [15:0] mem_q [CELLS];

	// Datapath controls.
	logic              mem_we, mem_re;
	logic [ADDR_W-1:0] mem_waddr, mem_raddr;
	logic [15:0]       mem_wdata;
	logic              cur_ld, sweep_clr, sweep_inc, copy_pend_d;
	logic              rsp_ld, cell_clr, cell_ld;
	logic [COL_W-1:0]  nxt_col;
	logic [ROW_W-1:0]  nxt_row;

	// Shared index unit and its operands.
	logic [COL_W-1:0]  idx_col;
	logic [ROW_W-1:0]  idx_row;
	logic [ADDR_W-1:0] idx;

	// Cursor advance for a character write.
	logic [COL_W-1:0]  adv_col;
	logic [ROW_W-1:0]  adv_row;
	logic              adv_scroll;
	logic              in_range;
	logic              is_newline;

	assign cmd_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign in_range   = (item_q.col < 8'(COLUMNS)) && (item_q.row < 8'(ROWS));
	assign is_newline = (item_q.char_code == NEWLINE);

	// Index unit: row times columns plus column, shared by all addressed ops.
	always_comb begin
		if (state_q == ST_EXEC && (item_q.op == OP_PUT || item_q.op == OP_READ)) begin
			idx_col = item_q.col[COL_W-1:0];
			idx_row = item_q.row[ROW_W-1:0];
		end else begin
			idx_col = cur_col_q;
			idx_row = cur_row_q;
		end
		idx = ADDR_W'(idx_row) * ADDR_W'(COLUMNS) + ADDR_W'(idx_col);
	end

	// Cursor advance with newline, column wrap and bottom-row detection.
	always_comb begin
		if (is_newline) begin
			adv_col = '0;
			adv_row = cur_row_q + ROW_W'(1);
		end else begin
			adv_col = cur_col_q + COL_W'(1);
			adv_row = cur_row_q;
			if (adv_col >= COL_W'(COLUMNS)) begin
				adv_col = '0;
				adv_row = cur_row_q + ROW_W'(1);
			end
		end
		adv_scroll = (adv_row >= ROW_W'(ROWS));
		if (adv_scroll) begin
			adv_row = ROW_W'(ROWS - 1);
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q) inside
			ST_INIT: begin
				if (sweep_q == LAST_ADDR) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (cmd_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				unique case (item_q.op)
					OP_WRITE: state_d = adv_scroll ? ST_SCROLL : ST_RESULT;
					OP_CLEAR: state_d = ST_CLEAR;
					OP_READ:  state_d = in_range ? ST_READ : ST_RESULT;
					default:  state_d = ST_RESULT;
				endcase
			end
			ST_READ: begin
				state_d = ST_RESULT;
			end
			ST_SCROLL: begin
				if (sweep_q == COPY_END && !copy_pend_q) state_d = ST_FILL;
			end
			ST_FILL, ST_CLEAR: begin
				if (sweep_q == LAST_ADDR) state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (!rsp_valid_q || !rsp_stall) state_d = ST_IDLE;
			end
		endcase
	end

	// Datapath controls per state.
	always_comb begin
		mem_we      = 1'b0;
		mem_waddr   = sweep_q;
		mem_wdata   = fill_q;
		mem_re      = 1'b0;
		mem_raddr   = idx;
		cur_ld      = 1'b0;
		nxt_col     = cur_col_q;
		nxt_row     = cur_row_q;
		sweep_clr   = 1'b0;
		sweep_inc   = 1'b0;
		copy_pend_d = 1'b0;
		rsp_ld      = 1'b0;
		cell_clr    = 1'b0;
		cell_ld     = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = BLANK_CELL;
				sweep_inc = 1'b1;
			end
			ST_IDLE: begin
			end
			ST_EXEC: begin
				cell_clr  = 1'b1;
				sweep_clr = 1'b1;
				mem_waddr = idx;
				mem_wdata = make_cell(item_q.char_code, item_q.fg_color, item_q.bg_color);
				unique case (item_q.op)
					OP_WRITE: begin
						mem_we  = !is_newline;
						cur_ld  = 1'b1;
						nxt_col = adv_col;
						nxt_row = adv_row;
					end
					OP_PUT: begin
						mem_we = in_range;
					end
					OP_SET: begin
						cur_ld  = 1'b1;
						nxt_col = (item_q.col >= 8'(COLUMNS)) ? COL_W'(COLUMNS - 1)
							: item_q.col[COL_W-1:0];
						nxt_row = (item_q.row >= 8'(ROWS)) ? ROW_W'(ROWS - 1)
							: item_q.row[ROW_W-1:0];
					end
					OP_CLEAR: begin
						cur_ld  = 1'b1;
						nxt_col = '0;
						nxt_row = '0;
					end
					OP_READ: begin
						mem_re = in_range;
					end
					default: begin
					end
				endcase
			end
			ST_READ: begin
				cell_ld = 1'b1;
			end
			ST_SCROLL: begin
				// Read one row below; the copy is written in the following cycle.
				mem_raddr = sweep_q + ADDR_W'(COLUMNS);
				if (sweep_q != COPY_END) begin
					mem_re      = 1'b1;
					copy_pend_d = 1'b1;
					sweep_inc   = 1'b1;
				end
			end
			ST_FILL: begin
				mem_we    = 1'b1;
				mem_wdata = SCROLL_CELL;
				sweep_inc = 1'b1;
			end
			ST_CLEAR: begin
				mem_we    = 1'b1;
				sweep_inc = 1'b1;
			end
			ST_RESULT: begin
				rsp_ld = !rsp_valid_q || !rsp_stall;
			end
		endcase
		// A pending scroll copy owns the write port.
		if (copy_pend_q) begin
			mem_we    = 1'b1;
			mem_waddr = copy_addr_q;
			mem_wdata = rd_data_q;
		end
	end

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			sweep_q     <= '0;
			copy_pend_q <= 1'b0;
			cur_col_q   <= '0;
			cur_row_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			copy_pend_q <= copy_pend_d;
			if (sweep_clr) begin
				sweep_q <= '0;
			end else if (sweep_inc) begin
				sweep_q <= sweep_q + ADDR_W'(1);
			end
			if (cur_ld) begin
				cur_col_q <= nxt_col;
				cur_row_q <= nxt_row;
			end
			if (rsp_ld) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) begin
			item_q <= cmd;
		end
		if (state_q == ST_EXEC) begin
			fill_q <= {item_q.bg_color, 4'h0, BLANK_CHAR};
		end
		copy_addr_q <= sweep_q;
		if (cell_clr) begin
			cell_q <= '0;
		end else if (cell_ld) begin
			cell_q <= rd_data_q;
		end
		if (rsp_ld) begin
			rsp_q.cursor_col   <= cur_col_q;
			rsp_q.cursor_row   <= cur_row_q;
			rsp_q.cursor_index <= idx;
			rsp_q.cell_data    <= cell_q;
		end
	end

	// Text store: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= mem_q[mem_raddr];
		end
	end

	// Checks.
	`TCW_ASSERT_NEXT(a_accept_exec, cmd_valid && !cmd_stall, state_q == ST_EXEC)
	`TCW_ASSERT_IMPL(a_col_range, rsp_valid, rsp.cursor_col < COL_W'(COLUMNS))
	`TCW_ASSERT_IMPL(a_row_range, rsp_valid, rsp.cursor_row < ROW_W'(ROWS))
	`TCW_ASSERT_IMPL(a_copy_in_scroll, copy_pend_q, state_q == ST_SCROLL)

endmodule

### tb/tb_text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives command words into the console engine under random idling and
// response stalls, tracks the screen store and cursor in a shadow copy, and
// compares every response word field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_text_console_writer;
	import tcw_pkg::*;

	// Shadow of the screen store and cursor, with the queue of cursor reports
	// still owed by the block.
	class console_tracker;
		logic [15:0]      text_mem [CELLS];
		logic [COL_W-1:0] cur_col;
		logic [ROW_W-1:0] cur_row;
		rsp_word_t        pending_reports [$];
		int               fails;

		function new();
			foreach (text_mem[i]) text_mem[i] = BLANK_CELL;
			cur_col = '0;
			cur_row = '0;
			fails = 0;
		endfunction

		// Every row moves up by one and the bottom row takes the scroll fill.
		function void scroll_up();
			for (int i = 0; i < CELLS - COLUMNS; i++) text_mem[i] = text_mem[i + COLUMNS];
			for (int i = CELLS - COLUMNS; i < CELLS; i++) text_mem[i] = SCROLL_CELL;
			cur_row = ROW_W'(ROWS - 1);
		endfunction

		// Applies one accepted command word and queues the report it should cause.
		function void note_cmd(cmd_word_t w);
			rsp_word_t   report;
			logic [15:0] word_read;
			bit          in_range;
			int          pos;
			word_read = '0;
			in_range = (w.col < COLUMNS) && (w.row < ROWS);
			pos = int'(w.row) * COLUMNS + int'(w.col);
			case (w.op)
				OP_WRITE: begin
					// A newline stores nothing; other characters land at the cursor.
					if (w.char_code == NEWLINE) begin
						cur_col = '0;
						cur_row = cur_row + 1'b1;
					end else begin
						if (cur_col < COLUMNS && cur_row < ROWS)
							text_mem[int'(cur_row) * COLUMNS + int'(cur_col)] =
								{w.bg_color, w.fg_color, w.char_code};
						cur_col = cur_col + 1'b1;
					end
					if (cur_col >= COLUMNS) begin
						cur_col = '0;
						cur_row = cur_row + 1'b1;
					end
					if (cur_row >= ROWS)
						scroll_up();
				end
				OP_PUT: begin
					if (in_range)
						text_mem[pos] = {w.bg_color, w.fg_color, w.char_code};
				end
				OP_SET: begin
					cur_col = (w.col >= COLUMNS) ? COL_W'(COLUMNS - 1) : COL_W'(w.col);
					cur_row = (w.row >= ROWS) ? ROW_W'(ROWS - 1) : ROW_W'(w.row);
				end
				OP_CLEAR: begin
					foreach (text_mem[i]) text_mem[i] = {w.bg_color, 4'h0, BLANK_CHAR};
					cur_col = '0;
					cur_row = '0;
				end
				OP_READ: begin
					if (in_range)
						word_read = text_mem[pos];
				end
				default: begin
				end
			endcase
			report.cursor_col = cur_col;
			report.cursor_row = cur_row;
			report.cursor_index = ADDR_W'(int'(cur_row) * COLUMNS + int'(cur_col));
			report.cell_data = word_read;
			pending_reports.push_back(report);
		endfunction

		function void complain(string msg);
			fails++;
			if (fails <= 10)
				$display("%0t: %s", $realtime, msg);
		endfunction

		// Compares one accepted response word with the oldest queued report.
		function void check_rsp(rsp_word_t got);
			rsp_word_t want;
			if (pending_reports.size() == 0) begin
				complain($sformatf("response with none outstanding: col=%0d row=%0d idx=%0d data=%h",
					got.cursor_col, got.cursor_row, got.cursor_index, got.cell_data));
				return;
			end
			want = pending_reports.pop_front();
			if (got.cursor_col !== want.cursor_col || got.cursor_row !== want.cursor_row ||
					got.cursor_index !== want.cursor_index || got.cell_data !== want.cell_data)
				complain($sformatf({"mismatch: expected col=%0d row=%0d idx=%0d data=%h, ",
					"got col=%0d row=%0d idx=%0d data=%h"},
					want.cursor_col, want.cursor_row, want.cursor_index, want.cell_data,
					got.cursor_col, got.cursor_row, got.cursor_index, got.cell_data));
		endfunction
	endclass

	// Spare command codes that the block must treat as no-ops.
	localparam logic [2:0] OP_SPARE_LO = 3'd5;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	localparam int RANDOM_ITEMS = 650;
	localparam int IDLE_PCT     = 20;
	localparam int DRAIN_CYCLES = 64;
	localparam int CYCLE_LIMIT  = 2_000_000;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      cmd_valid = 1'b0;
	logic      cmd_stall;
	cmd_word_t cmd       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_word_t rsp;

	console_tracker sb = new;
	int             issued = 0;
	int             cycle_count = 0;
	bit             no_idle = 1'b0;

	text_console_writer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Response side: check accepted words and stall at random.
	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_rsp(rsp);
		rsp_stall <= !no_idle && ($urandom_range(99) < IDLE_PCT);
	end

	// Offers one command word, after a random idle gap, and holds it until accepted.
	task automatic send_cmd(input cmd_word_t w);
		int gap;
		gap = 0;
		while (!no_idle && $urandom_range(99) < IDLE_PCT) gap++;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd <= w;
		@(posedge clk);
		while (cmd_stall) @(posedge clk);
		sb.note_cmd(w);
		issued++;
	endtask

	function automatic cmd_word_t cmd_of(logic [2:0] op, logic [7:0] ch, logic [7:0] c,
			logic [7:0] r, logic [3:0] fg, logic [3:0] bg);
		cmd_word_t w;
		w.op = op;
		w.char_code = ch;
		w.col = c;
		w.row = r;
		w.fg_color = fg;
		w.bg_color = bg;
		return w;
	endfunction

	function automatic cmd_word_t random_cmd(logic [2:0] op);
		return cmd_of(op, 8'($urandom), 8'($urandom), 8'($urandom),
			4'($urandom), 4'($urandom));
	endfunction

	// A position on screen, leaning toward the bottom rows where scrolling shows.
	function automatic cmd_word_t at_screen_pos(cmd_word_t w);
		w.col = 8'($urandom_range(COLUMNS - 1));
		w.row = ($urandom_range(99) < 30) ? 8'(ROWS - 1 - $urandom_range(1))
			: 8'($urandom_range(ROWS - 1));
		return w;
	endfunction

	// Cursor placement followed by a run of characters with some newlines.
	task automatic text_burst();
		cmd_word_t w;
		int        n;
		w = random_cmd(OP_SET);
		w.row = ($urandom_range(99) < 40) ? 8'(ROWS - 1) : 8'($urandom_range(ROWS - 1));
		w.col = ($urandom_range(99) < 30) ? 8'(COLUMNS - 1 - $urandom_range(3))
			: 8'($urandom_range(COLUMNS - 1));
		send_cmd(w);
		n = $urandom_range(12, 1);
		repeat (n) begin
			w = random_cmd(OP_WRITE);
			if ($urandom_range(99) < 12)
				w.char_code = NEWLINE;
			send_cmd(w);
		end
	endtask

	// A put, mostly on screen, often followed by a read of the same spot.
	task automatic put_then_read();
		cmd_word_t w;
		w = random_cmd(OP_PUT);
		if ($urandom_range(99) >= 15)
			w = at_screen_pos(w);
		send_cmd(w);
		if ($urandom_range(99) < 60) begin
			w.op = OP_READ;
			send_cmd(w);
		end
	endtask

	initial begin
		cmd_word_t w;
		int        pick;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part: field extremes, wrap, scroll, range limits and spare codes.
		send_cmd(cmd_of(OP_READ, 8'h00, 8'd0, 8'd0, 4'h0, 4'h0));
		send_cmd(cmd_of(OP_WRITE, 8'h00, 8'd0, 8'd0, 4'h0, 4'h0));
		send_cmd(cmd_of(OP_WRITE, 8'hFF, 8'hFF, 8'hFF, 4'hF, 4'hF));
		send_cmd(cmd_of(OP_READ, 8'h00, 8'd0, 8'd0, 4'h0, 4'h0));
		send_cmd(cmd_of(OP_READ, 8'h00, 8'd1, 8'd0, 4'h0, 4'h0));
		send_cmd(cmd_of(OP_WRITE, NEWLINE, 8'd0, 8'd0, 4'h3, 4'h4));
		send_cmd(cmd_of(OP_PUT, 8'hAA, 8'd79, 8'd24, 4'h5, 4'hA));
		send_cmd(cmd_of(OP_PUT, 8'h55, 8'd80, 8'd0, 4'h1, 4'h2));
		send_cmd(cmd_of(OP_PUT, 8'h55, 8'd0, 8'd25, 4'h1, 4'h2));
		send_cmd(cmd_of(OP_PUT, 8'h55, 8'd255, 8'd255, 4'hF, 4'hF));
		send_cmd(cmd_of(OP_READ, 8'h00, 8'd79, 8'd24, 4'h0, 4'h0));
		send_cmd(cmd_of(OP_READ, 8'h00, 8'd80, 8'd0, 4'h0, 4'h0));
		send_cmd(cmd_of(OP_READ, 8'h00, 8'd0, 8'd255, 4'h0, 4'h0));
		send_cmd(cmd_of(OP_SET, 8'h00, 8'd255, 8'd255, 4'h0, 4'h0));
		send_cmd(cmd_of(OP_SET, 8'h00, 8'd79, 8'd0, 4'h0, 4'h0));
		send_cmd(cmd_of(OP_WRITE, 8'h41, 8'd0, 8'd0, 4'h7, 4'h1));
		send_cmd(cmd_of(OP_SET, 8'h00, 8'd79, 8'd24, 4'h0, 4'h0));
		send_cmd(cmd_of(OP_WRITE, 8'h42, 8'd0, 8'd0, 4'hC, 4'h3));
		send_cmd(cmd_of(OP_READ, 8'h00, 8'd79, 8'd23, 4'h0, 4'h0));
		send_cmd(cmd_of(OP_SET, 8'h00, 8'd10, 8'd24, 4'h0, 4'h0));
		send_cmd(cmd_of(OP_WRITE, NEWLINE, 8'd0, 8'd0, 4'h0, 4'h0));
		send_cmd(cmd_of(OP_READ, 8'h00, 8'd5, 8'd24, 4'h0, 4'h0));
		send_cmd(cmd_of(OP_SPARE_LO, 8'h12, 8'd3, 8'd3, 4'h2, 4'h2));
		send_cmd(cmd_of(OP_SPARE_HI, 8'hFF, 8'd255, 8'd255, 4'hF, 4'hF));
		send_cmd(cmd_of(OP_CLEAR, 8'h00, 8'd0, 8'd0, 4'h0, 4'hA));
		send_cmd(cmd_of(OP_READ, 8'h00, 8'd3, 8'd3, 4'h0, 4'h0));

		// Random part: mostly well-formed sequences, some noise, one steady stretch.
		issued = 0;
		while (issued < RANDOM_ITEMS) begin
			no_idle = (issued >= 250 && issued < 400);
			pick = $urandom_range(99);
			if (pick < 40) begin
				text_burst();
			end else if (pick < 60) begin
				put_then_read();
			end else if (pick < 75) begin
				w = random_cmd(OP_READ);
				if ($urandom_range(99) >= 15)
					w = at_screen_pos(w);
				send_cmd(w);
			end else if (pick < 85) begin
				send_cmd(random_cmd(OP_SET));
			end else if (pick < 87) begin
				send_cmd(random_cmd(OP_CLEAR));
			end else begin
				send_cmd(random_cmd(3'($urandom_range(7))));
			end
		end
		no_idle = 1'b0;
		cmd_valid <= 1'b0;

		// Drain outstanding reports, then watch for stray responses.
		while (sb.pending_reports.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.fails == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
